### design/esc_pkg.sv
// Shared constants and types for the epoch seconds to calendar converter.
`default_nettype none
package esc_pkg;

    localparam int unsigned EPOCH_W   = 32;
    localparam int unsigned ZONE_W    = 17;
    localparam int unsigned OUT_W     = 48;
    localparam int unsigned CONST_W   = 11;
    localparam int unsigned REM_W     = 11;

    localparam logic [ZONE_W-1:0] ZONE_RESET = 17'd7200;

    localparam logic [CONST_W-1:0] SEC_PER_MIN  = 11'd60;
    localparam logic [CONST_W-1:0] HR_PER_DAY   = 11'd24;
    localparam logic [CONST_W-1:0] DAY_PER_WEEK = 11'd7;
    localparam logic [CONST_W-1:0] CYCLE_DAYS   = 11'd1461;

    localparam logic [31:0] RECIP_60   = 32'((64'd1 << 32) / 64'd60);
    localparam logic [31:0] RECIP_24   = 32'((64'd1 << 32) / 64'd24);
    localparam logic [31:0] RECIP_7    = 32'((64'd1 << 32) / 64'd7);
    localparam logic [31:0] RECIP_1461 = 32'((64'd1 << 32) / 64'd1461);

    localparam logic [REM_W-1:0] YEAR_DAYS    = 11'd365;
    localparam logic [REM_W-1:0] TWO_YEARS    = 11'd730;
    localparam logic [REM_W-1:0] LEAP_END_DAY = 11'd1096;
    localparam logic [11:0]      BASE_YEAR    = 12'd1970;
    localparam logic [31:0]      WEEKDAY_BIAS = 32'd4;

    localparam logic [3:0] LAST_MONTH = 4'd11;
    localparam logic [3:0] FEB_INDEX  = 4'd1;
    localparam logic [1:0] LEAP_SLOT  = 2'd2;
    localparam logic [1:0] LAST_SLOT  = 2'd3;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [1:0] {
        DIV_60   = 2'd0,
        DIV_24   = 2'd1,
        DIV_7    = 2'd2,
        DIV_1461 = 2'd3
    } div_sel_t;

endpackage
`default_nettype wire

### design/esc_div_unit.sv
// Shared divide-by-constant unit using a registered reciprocal multiply and one combinational correction.
`default_nettype none
module esc_div_unit (
    input  wire logic                      clk,
    input  wire logic [31:0]               x,
    input  wire esc_pkg::div_sel_t         sel,
    output logic [31:0]                    q,
    output logic [31:0]                    r
);
    import esc_pkg::*;

    logic [63:0]        prod_reg;
    logic [31:0]        x_reg;
    logic [CONST_W-1:0] c_reg;
    logic [CONST_W-1:0] c;
    logic [31:0]        recip;
    logic [31:0]        q_est;
    logic [31:0]        qc;
    logic [31:0]        r_est;
    logic [31:0]        c_ext;

    always_comb
    begin
        case (sel)
            DIV_60:
            begin
                c     = SEC_PER_MIN;
                recip = RECIP_60;
            end
            DIV_24:
            begin
                c     = HR_PER_DAY;
                recip = RECIP_24;
            end
            DIV_7:
            begin
                c     = DAY_PER_WEEK;
                recip = RECIP_7;
            end
            DIV_1461:
            begin
                c     = CYCLE_DAYS;
                recip = RECIP_1461;
            end
            default:
            begin
                c     = SEC_PER_MIN;
                recip = RECIP_60;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(x) * 64'(recip);
        x_reg    <= x;
        c_reg    <= c;
    end

    always_comb
    begin
        c_ext = {{(32-CONST_W){1'b0}}, c_reg};
        q_est = prod_reg[63:32];
        qc    = q_est * c_ext;
        r_est = x_reg - qc;
        if (r_est >= c_ext)
        begin
            q = q_est + 32'd1;
            r = r_est - c_ext;
        end
        else
        begin
            q = q_est;
            r = r_est;
        end
    end

endmodule
`default_nettype wire

### design/epoch_seconds_to_calendar_top.sv
// Top level: zone offset register, conversion sequencer and output register.
// Sequence: five passes through the shared divide unit (second, minute, hour,
// weekday, four-year cycle), then a year step and a month walk. A new input is
// taken only in idle, after the previous result has been loaded into the output
// register, which waits while the previous result is still held by m_tready low.
// Reset: rst_n asynchronous, active low; clears control and loads zone offset 7200.
`default_nettype none
module epoch_seconds_to_calendar_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [16:0] cfg_wr_data,   // zone_offset_seconds
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // epoch_seconds[31:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // second_of_minute[5:0], minute_of_hour[11:6], hour_of_day[16:12],
    // day_of_week[19:17], calendar_year[31:20], month_number[35:32],
    // day_of_month[40:36], zero[47:41]
    output logic [47:0]      m_tdata
);
    import esc_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_SEC_ISS = 14'b00000000000010,
        S_SEC_CAP = 14'b00000000000100,
        S_MIN_ISS = 14'b00000000001000,
        S_MIN_CAP = 14'b00000000010000,
        S_HR_ISS  = 14'b00000000100000,
        S_HR_CAP  = 14'b00000001000000,
        S_WD_ISS  = 14'b00000010000000,
        S_WD_CAP  = 14'b00000100000000,
        S_CYC_ISS = 14'b00001000000000,
        S_CYC_CAP = 14'b00010000000000,
        S_YEAR    = 14'b00100000000000,
        S_MONTH   = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [ZONE_W-1:0]  zone_reg;
    logic               m_tvalid_reg, m_tvalid_next;

    logic [31:0]        work_reg, work_next;
    logic [5:0]         sec_reg, sec_next;
    logic [5:0]         min_reg, min_next;
    logic [4:0]         hr_reg, hr_next;
    logic [2:0]         wd_reg, wd_next;
    logic [11:0]        year_reg, year_next;
    logic [1:0]         n_reg, n_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [3:0]         mon_reg, mon_next;
    logic [OUT_W-1:0]   out_reg, out_next;

    logic [31:0]        div_x;
    div_sel_t           div_sel;
    logic [31:0]        div_q;
    logic [31:0]        div_r;
    logic [1:0]         n_calc;
    logic [REM_W-1:0]   year_sub;
    logic [5:0]         mlen;
    logic               accept_in;
    logic               out_free;

    esc_div_unit u_div (
        .clk (clk),
        .x   (div_x),
        .sel (div_sel),
        .q   (div_q),
        .r   (div_r)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign accept_in = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_reg;

    always_comb
    begin
        case (state_reg)
            S_WD_ISS:
            begin
                div_x   = work_reg + WEEKDAY_BIAS;
                div_sel = DIV_7;
            end
            S_HR_ISS:
            begin
                div_x   = work_reg;
                div_sel = DIV_24;
            end
            S_CYC_ISS:
            begin
                div_x   = work_reg;
                div_sel = DIV_1461;
            end
            default:
            begin
                div_x   = work_reg;
                div_sel = DIV_60;
            end
        endcase
    end

    always_comb
    begin
        if (rem_reg >= LEAP_END_DAY)
        begin
            n_calc   = 2'd3;
            year_sub = LEAP_END_DAY;
        end
        else if (rem_reg >= TWO_YEARS)
        begin
            n_calc   = 2'd2;
            year_sub = TWO_YEARS;
        end
        else if (rem_reg >= YEAR_DAYS)
        begin
            n_calc   = 2'd1;
            year_sub = YEAR_DAYS;
        end
        else
        begin
            n_calc   = 2'd0;
            year_sub = '0;
        end
        mlen = {1'b0, MONTH_LEN[mon_reg]}
             + {5'd0, (mon_reg == FEB_INDEX) && (n_reg == LEAP_SLOT)};
    end

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        work_next     = work_reg;
        sec_next      = sec_reg;
        min_next      = min_reg;
        hr_next       = hr_reg;
        wd_next       = wd_reg;
        year_next     = year_reg;
        n_next        = n_reg;
        rem_next      = rem_reg;
        mon_next      = mon_reg;
        out_next      = out_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    work_next  = s_tdata + {{(EPOCH_W-ZONE_W){zone_reg[ZONE_W-1]}}, zone_reg};
                    state_next = S_SEC_ISS;
                end
            end
            S_SEC_ISS: state_next = S_SEC_CAP;
            S_SEC_CAP:
            begin
                sec_next   = div_r[5:0];
                work_next  = div_q;
                state_next = S_MIN_ISS;
            end
            S_MIN_ISS: state_next = S_MIN_CAP;
            S_MIN_CAP:
            begin
                min_next   = div_r[5:0];
                work_next  = div_q;
                state_next = S_HR_ISS;
            end
            S_HR_ISS: state_next = S_HR_CAP;
            S_HR_CAP:
            begin
                hr_next    = div_r[4:0];
                work_next  = div_q;
                state_next = S_WD_ISS;
            end
            S_WD_ISS: state_next = S_WD_CAP;
            S_WD_CAP:
            begin
                wd_next    = div_r[2:0];
                state_next = S_CYC_ISS;
            end
            S_CYC_ISS: state_next = S_CYC_CAP;
            S_CYC_CAP:
            begin
                year_next  = BASE_YEAR + {div_q[9:0], 2'b00};
                rem_next   = div_r[REM_W-1:0];
                state_next = S_YEAR;
            end
            S_YEAR:
            begin
                n_next     = n_calc;
                year_next  = year_reg + {10'd0, n_calc};
                rem_next   = rem_reg - year_sub;
                mon_next   = '0;
                state_next = S_MONTH;
            end
            S_MONTH:
            begin
                if ((mon_reg == LAST_MONTH) || (rem_reg < {5'd0, mlen}))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next = rem_reg - {5'd0, mlen};
                    mon_next = mon_reg + 4'd1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next      = {7'd0, rem_reg[4:0] + 5'd1, mon_reg + 4'd1, year_reg,
                                     wd_reg, hr_reg, min_reg, sec_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            zone_reg     <= ZONE_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                zone_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        sec_reg  <= sec_next;
        min_reg  <= min_next;
        hr_reg   <= hr_next;
        wd_reg   <= wd_next;
        year_reg <= year_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        mon_reg  <= mon_next;
        out_reg  <= out_next;
    end

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after accept");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[35:32] >= 4'd1 && m_tdata[35:32] <= 4'd12
                      && m_tdata[40:36] != 5'd0))
        else $error("month or day out of range");

    a_month_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MONTH) |-> (mon_reg <= LAST_MONTH))
        else $error("month index past December");
`endif

endmodule
`default_nettype wire

### verif/tb_epoch_seconds_to_calendar_top.sv
// Testbench for epoch_seconds_to_calendar_top: every converted date is checked against a predictor or table.
module tb_epoch_seconds_to_calendar_top;

    import esc_pkg::*;

    localparam int unsigned SECS_PER_DAY   = 86400;
    localparam int unsigned DAYS_PER_CYCLE = 1461;
    localparam int unsigned DAYS_PER_YEAR  = 365;
    localparam int unsigned LEAP_DEC31     = 1095;
    localparam int unsigned FIRST_YEAR     = 1970;
    localparam int unsigned LAST_DAY_INDEX = 49709;
    localparam int unsigned ITEMS_PER_ZONE = 100;
    localparam int unsigned ZONE_PHASES    = 11;
    localparam int unsigned FIXED_ZONES    = 8;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned DIR_ROWS       = 21;

    localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    localparam int unsigned EDGE_DAYS [16] = '{
        0, 30, 31, 58, 59, 364, 365, 729, 730, 788, 789, 790, 1094, 1095, 1096, 1460
    };

    typedef struct packed {
        logic [6:0]  pad;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [2:0]  dow;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        cal_t               cal;
    } pending_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [ZONE_W-1:0]  zone;
        bit                 known;
        int                 year;
        int                 month;
        int                 day;
        int                 dow;
        int                 hour;
        int                 minute;
        int                 second;
    } vector_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [ZONE_W-1:0]  cfg_wr_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [EPOCH_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;

    pending_t           pending_dates [$];
    logic [ZONE_W-1:0]  zone_now = ZONE_RESET;
    int unsigned        mismatch_cnt = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        ready_hold = 0;
    bit                 steady_feed = 1'b0;

    vector_t dir_rows [DIR_ROWS] = '{
        '{32'd0,          17'd7200,     1'b1, 1970, 1, 1, 4, 2, 0, 0},
        '{32'hFFFFFFFF,   17'd7200,     1'b1, 1970, 1, 1, 4, 1, 59, 59},
        '{32'd0,          17'd0,        1'b1, 1970, 1, 1, 4, 0, 0, 0},
        '{32'd59,         17'd0,        1'b1, 1970, 1, 1, 4, 0, 0, 59},
        '{32'd86399,      17'd0,        1'b1, 1970, 1, 1, 4, 23, 59, 59},
        '{32'd31535999,   17'd0,        1'b1, 1970, 12, 31, 4, 23, 59, 59},
        '{32'd63071999,   17'd0,        1'b1, 1971, 12, 31, 5, 23, 59, 59},
        '{32'd68169600,   17'd0,        1'b1, 1972, 2, 29, 2, 0, 0, 0},
        '{32'd94607999,   17'd0,        1'b1, 1972, 12, 30, 6, 23, 59, 59},
        '{32'd94608000,   17'd0,        1'b1, 1972, 12, 31, 0, 0, 0, 0},
        '{32'd94694400,   17'd0,        1'b1, 1973, 1, 1, 1, 0, 0, 0},
        '{32'd4107542400, 17'd0,        1'b0, 0, 0, 0, 0, 0, 0, 0},
        '{32'd4133980800, 17'd0,        1'b0, 0, 0, 0, 0, 0, 0, 0},
        '{32'hFFFFFFFF,   17'd0,        1'b0, 0, 0, 0, 0, 0, 0, 0},
        '{32'hFFFFFFFF,   17'd1,        1'b1, 1970, 1, 1, 4, 0, 0, 0},
        '{32'd0,          17'h1FFFF,    1'b0, 0, 0, 0, 0, 0, 0, 0},
        '{32'd0,          17'h10000,    1'b0, 0, 0, 0, 0, 0, 0, 0},
        '{32'hFFFFFFFF,   17'h0FFFF,    1'b1, 1970, 1, 1, 4, 18, 12, 14},
        '{32'h80000000,   -17'sd50400,  1'b0, 0, 0, 0, 0, 0, 0, 0},
        '{32'd0,          -17'sd50400,  1'b0, 0, 0, 0, 0, 0, 0, 0},
        '{32'd12345678,   17'd50400,    1'b0, 0, 0, 0, 0, 0, 0, 0}
    };

    logic [ZONE_W-1:0] zone_plan [FIXED_ZONES] = '{
        17'd0, -17'sd50400, 17'd50400, 17'h10000, 17'h0FFFF, 17'd3600, 17'h1FFFF, 17'd7200
    };

    epoch_seconds_to_calendar_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cal_t calendar_of(input logic [EPOCH_W-1:0] epoch,
                                         input logic [ZONE_W-1:0] zone);
        logic [31:0] local_s;
        int unsigned days;
        int unsigned doy;
        int unsigned cyc_yr;
        int unsigned mon;
        int unsigned len;
        cal_t        c;
        local_s = epoch + {{(32 - ZONE_W){zone[ZONE_W-1]}}, zone};
        c = '0;
        c.second = 6'(local_s % 60);
        c.minute = 6'((local_s / 60) % 60);
        c.hour   = 5'((local_s / 3600) % 24);
        days     = local_s / SECS_PER_DAY;
        c.dow    = 3'((days + 4) % 7);
        doy      = days % DAYS_PER_CYCLE;
        cyc_yr   = ((doy >= LEAP_DEC31) ? doy - 1 : doy) / DAYS_PER_YEAR;
        if (cyc_yr > 3)
            cyc_yr = 3;
        doy    = doy - cyc_yr * DAYS_PER_YEAR - ((cyc_yr == 3) ? 1 : 0);
        c.year = 12'(FIRST_YEAR + (days / DAYS_PER_CYCLE) * 4 + cyc_yr);
        mon = 0;
        while (mon < 11)
        begin
            len = DAYS_IN_MONTH[mon] + ((mon == 1 && cyc_yr == 2) ? 1 : 0);
            if (doy < len)
                break;
            doy = doy - len;
            mon++;
        end
        c.month = 4'(mon + 1);
        c.day   = 5'(doy + 1);
        return c;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // aim the local time at year and month edges, or anywhere
    function automatic logic [EPOCH_W-1:0] pick_epoch(input logic [ZONE_W-1:0] zone);
        int unsigned days;
        int unsigned sec;
        logic [31:0] local_s;
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2: days = $urandom_range(0, LAST_DAY_INDEX);
            default: days = $urandom_range(0, 33) * DAYS_PER_CYCLE
                            + EDGE_DAYS[$urandom_range(0, 15)];
        endcase
        case ($urandom_range(0, 2))
            0: sec = 0;
            1: sec = SECS_PER_DAY - 1;
            default: sec = $urandom_range(0, SECS_PER_DAY - 1);
        endcase
        local_s = days * SECS_PER_DAY + sec;
        return local_s - {{(32 - ZONE_W){zone[ZONE_W-1]}}, zone};
    endfunction

    task automatic send_epoch(input logic [EPOCH_W-1:0] epoch, input cal_t want);
        int unsigned gap;
        gap = steady_feed ? 0 : idle_len();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= epoch;
        do
            @(posedge clk);
        while (!s_tready);
        pending_dates.push_back('{epoch, want});
    endtask

    // drain, then write the offset while the converter is idle
    task automatic set_zone(input logic [ZONE_W-1:0] zone);
        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= zone;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        zone_now = zone;
    endtask

    task automatic check_field(input string name, input int want, input int got,
                               input logic [EPOCH_W-1:0] epoch);
        if (want != got)
        begin
            $display("%0t: epoch %0d %s expected %0d, actual %0d",
                     $time, epoch, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        int unsigned stall;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (m_tready)
        begin
            stall = idle_len();
            if (stall != 0)
            begin
                m_tready   <= 1'b0;
                ready_hold <= stall - 1;
            end
            else
                ready_hold <= ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 15);
        end
        else
        begin
            m_tready   <= 1'b1;
            ready_hold <= ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 15);
        end
    end

    always @(posedge clk)
    begin
        pending_t exp_item;
        cal_t     got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_dates.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
                mismatch_cnt++;
            end
            else
            begin
                exp_item = pending_dates.pop_front();
                check_field("second", exp_item.cal.second, got.second, exp_item.epoch);
                check_field("minute", exp_item.cal.minute, got.minute, exp_item.epoch);
                check_field("hour", exp_item.cal.hour, got.hour, exp_item.epoch);
                check_field("weekday", exp_item.cal.dow, got.dow, exp_item.epoch);
                check_field("year", exp_item.cal.year, got.year, exp_item.epoch);
                check_field("month", exp_item.cal.month, got.month, exp_item.epoch);
                check_field("day", exp_item.cal.day, got.day, exp_item.epoch);
                check_field("pad", exp_item.cal.pad, got.pad, exp_item.epoch);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        cal_t              want;
        logic [ZONE_W-1:0] zone;
        logic [EPOCH_W-1:0] epoch;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].zone != zone_now)
                set_zone(dir_rows[k].zone);
            if (dir_rows[k].known)
            begin
                want        = '0;
                want.year   = 12'(dir_rows[k].year);
                want.month  = 4'(dir_rows[k].month);
                want.day    = 5'(dir_rows[k].day);
                want.dow    = 3'(dir_rows[k].dow);
                want.hour   = 5'(dir_rows[k].hour);
                want.minute = 6'(dir_rows[k].minute);
                want.second = 6'(dir_rows[k].second);
            end
            else
                want = calendar_of(dir_rows[k].epoch, dir_rows[k].zone);
            send_epoch(dir_rows[k].epoch, want);
        end

        for (int p = 0; p < ZONE_PHASES; p++)
        begin
            zone = (p < FIXED_ZONES) ? zone_plan[p] : ZONE_W'($urandom_range(0, 17'h1FFFF));
            set_zone(zone);
            steady_feed = (p % 4 == 3);
            for (int n = 0; n < ITEMS_PER_ZONE; n++)
            begin
                epoch = pick_epoch(zone_now);
                send_epoch(epoch, calendar_of(epoch, zone_now));
            end
        end

        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
